// File: hdl/bsa_pkg.sv
// shared types and constants of the bitmap slot allocator
package bsa_pkg;

  localparam int CLS_W   = 4;
  localparam int REQ_W   = 12;
  localparam int OFF_W   = 12;
  localparam int LIM_W   = 13;
  localparam int SIZE_W  = 10;
  localparam int IDX_W   = 11;
  localparam int GRP_W   = 5;
  localparam int BIT_W   = 5;
  localparam int END_W   = 24;

  localparam logic [LIM_W-1:0] LIMIT_RESET     = 13'd3948;
  localparam logic [REQ_W-1:0] TOO_LARGE_BYTES = 12'd1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bsa_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } bsa_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MODIFY
  } bsa_back_state_t;

  // classified request as it travels from front to back
  typedef struct packed {
    bsa_op_t              op;
    logic                 early;
    bsa_status_t          status;
    logic [CLS_W-1:0]     cls;
    logic [GRP_W-1:0]     grp;
    logic [BIT_W-1:0]     slot_bit;
  } bsa_item_t;

endpackage

// File: hdl/bsa_if.sv
// handshake channels: request, result and configuration write
interface bsa_req_if;
  logic                         valid;
  logic                         ready;
  bsa_pkg::bsa_op_t             op;
  logic [bsa_pkg::REQ_W-1:0]    request_bytes;
  logic [bsa_pkg::CLS_W-1:0]    free_class;
  logic [bsa_pkg::OFF_W-1:0]    free_offset;

  modport source (output valid, op, request_bytes, free_class, free_offset, input ready);
  modport sink (input valid, op, request_bytes, free_class, free_offset, output ready);
endinterface

interface bsa_res_if;
  logic                         valid;
  logic                         ready;
  bsa_pkg::bsa_status_t         status;
  logic [bsa_pkg::CLS_W-1:0]    slot_class;
  logic [bsa_pkg::OFF_W-1:0]    slot_offset;

  modport source (output valid, status, slot_class, slot_offset, input ready);
  modport sink (input valid, status, slot_class, slot_offset, output ready);
endinterface

interface bsa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bsa_pkg::LIM_W-1:0]    usable_limit;

  modport source (output valid, usable_limit, input ready);
  modport sink (input valid, usable_limit, output ready);
endinterface

// File: hdl/bsa_ram.sv
// generic single-write, single-read ram with registered read data
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 320
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bsa_front.sv
// front end: takes request beats, works out class, slot index and early status
module bsa_front #(
  parameter int CLASS_COUNT     = 10,
  parameter int GROUPS          = 32,
  parameter int SLOTS_PER_GROUP = 32
) (
  bsa_req_if.sink             req,
  input  logic                clearing,
  input  logic                q_ready,
  output logic                q_push,
  output bsa_pkg::bsa_item_t  q_item
);

  import bsa_pkg::*;

  logic [SIZE_W-1:0] size;
  logic [CLS_W-1:0]  acls;
  logic              too_large;
  logic              cls_ok;
  logic [OFF_W-1:0]  shifted;
  logic [IDX_W-1:0]  fidx;
  logic [IDX_W-1:0]  rem;
  logic              beyond;
  logic [GRP_W-1:0]  fgrp;

  assign req.ready = q_ready && !clearing;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    // zero bytes counts as one
    size = (req.request_bytes == '0) ? SIZE_W'(1) : req.request_bytes[SIZE_W-1:0];
    acls = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) begin
        acls = CLS_W'(i + 1);
      end
    end
    too_large = (req.request_bytes >= TOO_LARGE_BYTES) || (acls > CLS_W'(CLASS_COUNT));

    cls_ok  = (req.free_class != '0) && (req.free_class <= CLS_W'(CLASS_COUNT));
    shifted = req.free_offset >> req.free_class;
    fidx    = shifted[IDX_W-1:0];
    beyond  = fidx >= IDX_W'(GROUPS * SLOTS_PER_GROUP);

    // group = slot index over slots per group, by comparing against each boundary
    fgrp = '0;
    for (int k = 1; k < GROUPS; k++) begin
      if (fidx >= IDX_W'(k * SLOTS_PER_GROUP)) begin
        fgrp = GRP_W'(k);
      end
    end
    rem = fidx - IDX_W'(fgrp) * IDX_W'(SLOTS_PER_GROUP);

    q_item.op       = req.op;
    q_item.grp      = fgrp;
    q_item.slot_bit = rem[BIT_W-1:0];
    if (req.op == OP_ALLOC) begin
      q_item.cls    = acls;
      q_item.early  = too_large;
      q_item.status = too_large ? ST_TOO_LARGE : ST_OK;
    end else begin
      q_item.cls    = req.free_class;
      q_item.early  = !cls_ok || beyond;
      q_item.status = (!cls_ok || beyond) ? ST_BAD_FREE : ST_OK;
    end
  end

endmodule

// File: hdl/bsa_queue.sv
// two-entry queue between front and back
module bsa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bsa_pkg::bsa_item_t  push_item,
  output logic                push_ready,
  input  logic                pop,
  output logic                head_valid,
  output bsa_pkg::bsa_item_t  head_item
);

  import bsa_pkg::*;

  bsa_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign head_valid = count != 2'd0;
  assign head_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/bsa_back.sv
// back end: group search, slot word read-modify-write and result register
module bsa_back #(
  parameter int CLASS_COUNT     = 10,
  parameter int GROUPS          = 32,
  parameter int SLOTS_PER_GROUP = 32,
  parameter int PAGE_BYTES      = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bsa_pkg::LIM_W-1:0]  usable_limit,
  input  logic                       q_valid,
  input  bsa_pkg::bsa_item_t         q_item,
  output logic                       q_pop,
  output logic                       clearing,
  bsa_res_if.source                  res
);

  import bsa_pkg::*;

  localparam int DEPTH = CLASS_COUNT * GROUPS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = CLASS_COUNT > 1 ? $clog2(CLASS_COUNT) : 1;
  localparam int GW    = GROUPS > 1 ? $clog2(GROUPS) : 1;
  localparam int SW    = SLOTS_PER_GROUP;

  bsa_back_state_t state, state_next;

  logic [GROUPS-1:0]  gfull [CLASS_COUNT];
  logic [AW-1:0]      clr_cnt;

  bsa_op_t            cur_op;
  logic [CLS_W-1:0]   cur_cls;
  logic [CW-1:0]      cur_row;
  logic [GRP_W-1:0]   cur_grp;
  logic [BIT_W-1:0]   cur_bit;

  logic               res_valid;
  bsa_status_t        res_status;
  logic [CLS_W-1:0]   res_class;
  logic [OFF_W-1:0]   res_offset;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SW-1:0]      ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [SW-1:0]      ram_rdata;

  logic               out_free;
  logic               load;
  bsa_status_t        load_status;
  logic [CLS_W-1:0]   load_class;
  logic [OFF_W-1:0]   load_offset;
  logic               gf_we;
  logic               gf_val;
  logic [CLS_W-1:0]   head_row_full;
  logic [CW-1:0]      head_row;
  logic [GROUPS-1:0]  head_gfull;
  logic               found;
  logic [GRP_W-1:0]   found_grp;
  logic [GRP_W-1:0]   sel_grp;
  logic [BIT_W-1:0]   zero_bit;
  logic [BIT_W-1:0]   use_bit;
  logic [SW-1:0]      bit_mask;
  logic [SW-1:0]      new_word;
  logic [IDX_W-1:0]   idx;
  logic [END_W-1:0]   slot_end;
  logic [END_W-1:0]   slot_start;
  logic [END_W-1:0]   limit_eff;

  bsa_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing    = state == BK_CLEAR;
  assign out_free    = !res_valid || res.ready;
  assign res.valid   = res_valid;
  assign res.status  = res_status;
  assign res.slot_class  = res_class;
  assign res.slot_offset = res_offset;

  always_comb begin
    limit_eff = (END_W'(usable_limit) > END_W'(PAGE_BYTES)) ? END_W'(PAGE_BYTES)
                                                             : END_W'(usable_limit);

    head_row_full = q_item.cls - CLS_W'(1);
    head_row      = head_row_full[CW-1:0];
    head_gfull    = (head_row_full < CLS_W'(CLASS_COUNT)) ? gfull[head_row] : '1;
    // lowest group not marked full
    found     = 1'b0;
    found_grp = '0;
    for (int k = GROUPS - 1; k >= 0; k--) begin
      if (!head_gfull[k]) begin
        found     = 1'b1;
        found_grp = GRP_W'(k);
      end
    end
    sel_grp = (q_item.op == OP_ALLOC) ? found_grp : q_item.grp;

    // lowest free slot of the word just read
    zero_bit = '0;
    for (int k = SW - 1; k >= 0; k--) begin
      if (!ram_rdata[k]) begin
        zero_bit = BIT_W'(k);
      end
    end
    use_bit    = (cur_op == OP_ALLOC) ? zero_bit : cur_bit;
    bit_mask   = SW'(1) << use_bit;
    idx        = IDX_W'(cur_grp) * IDX_W'(SLOTS_PER_GROUP) + IDX_W'(use_bit);
    slot_start = END_W'(idx) << cur_cls;
    slot_end   = (END_W'(idx) + END_W'(1)) << cur_cls;
    new_word   = (cur_op == OP_ALLOC) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    state_next  = state;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(int'(cur_row) * GROUPS + int'(cur_grp));
    ram_wdata   = new_word;
    ram_re      = 1'b0;
    ram_raddr   = AW'(int'(head_row) * GROUPS + int'(sel_grp));
    load        = 1'b0;
    load_status = ST_OK;
    load_class  = '0;
    load_offset = '0;
    gf_we       = 1'b0;
    gf_val      = 1'b0;

    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          if (q_item.early) begin
            if (out_free) begin
              q_pop       = 1'b1;
              load        = 1'b1;
              load_status = q_item.status;
            end
          end else if (q_item.op == OP_ALLOC && !found) begin
            if (out_free) begin
              q_pop       = 1'b1;
              load        = 1'b1;
              load_status = ST_FULL;
            end
          end else begin
            q_pop      = 1'b1;
            ram_re     = 1'b1;
            state_next = BK_MODIFY;
          end
        end
      end
      BK_MODIFY: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = BK_IDLE;
          if (cur_op == OP_ALLOC) begin
            if (slot_end > limit_eff) begin
              load_status = ST_FULL;
            end else begin
              ram_we      = 1'b1;
              gf_we       = 1'b1;
              gf_val      = &new_word;
              load_status = ST_OK;
              load_class  = cur_cls;
              load_offset = slot_start[OFF_W-1:0];
            end
          end else begin
            ram_we = 1'b1;
            gf_we  = 1'b1;
            gf_val = 1'b0;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        gfull[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (gf_we) begin
        gfull[cur_row][cur_grp[GW-1:0]] <= gf_val;
      end
    end
    if (q_pop) begin
      cur_op  <= q_item.op;
      cur_cls <= q_item.cls;
      cur_row <= head_row;
      cur_grp <= sel_grp;
      cur_bit <= q_item.slot_bit;
    end
    if (load) begin
      res_status <= load_status;
      res_class  <= load_class;
      res_offset <= load_offset;
    end
  end

endmodule

// File: hdl/two_level_bitmap_slot_allocator_top.sv
// top level of the two-level bitmap slot allocator
//
// req carries one request per beat: op selects allocate or free; an allocate
// uses request_bytes, a free uses free_class and free_offset. res returns one
// beat per request with status, slot_class and slot_offset. cfg writes the
// usable byte limit; it is always ready and should only be written while the
// block has no request in flight.
// a request is classified on the beat it is taken and queued (two entries);
// the back end then works on it in a pick state and a modify state: a group
// pick from the class summary word with the slot word read, then the slot
// word update and the result load, which waits while the result register is
// full. requests that end early (too large, bad free, class full) are
// resolved in the pick state alone. the back end takes no new request until
// the read-modify-write of the slot word in the map ram is done.
// after reset the slot map is swept clear, one word a cycle, over all
// CLASS_COUNT*GROUPS words (320 by default); req.ready stays low until done.
// when res is stalled the result register holds and the queue fills, then
// req.ready drops.
module two_level_bitmap_slot_allocator_top #(
  parameter int CLASS_COUNT     = 10,
  parameter int GROUPS          = 32,
  parameter int SLOTS_PER_GROUP = 32,
  parameter int PAGE_BYTES      = 4096
) (
  input  logic      clk,
  input  logic      rst,
  bsa_req_if.sink   req,
  bsa_res_if.source res,
  bsa_cfg_if.sink   cfg
);

  import bsa_pkg::*;

  logic [LIM_W-1:0] usable_limit;
  logic             clearing;
  logic             q_push;
  logic             q_ready;
  logic             q_pop;
  logic             q_valid;
  bsa_item_t        push_item;
  bsa_item_t        head_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      usable_limit <= cfg.usable_limit;
    end
  end

  bsa_front #(
    .CLASS_COUNT     (CLASS_COUNT),
    .GROUPS          (GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) u_front (
    .req      (req),
    .clearing (clearing),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  bsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  bsa_back #(
    .CLASS_COUNT     (CLASS_COUNT),
    .GROUPS          (GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
    .PAGE_BYTES      (PAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .usable_limit (usable_limit),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .res          (res)
  );

endmodule

// File: tb/bsa_grant_checker.sv
`timescale 1ns / 100ps
// checker: mirrors the slot maps, predicts every result beat and compares it
module bsa_grant_checker #(
  parameter int CLASS_COUNT     = 10,
  parameter int GROUPS          = 32,
  parameter int SLOTS_PER_GROUP = 32,
  parameter int PAGE_BYTES      = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  bsa_pkg::bsa_op_t          req_op,
  input  logic [bsa_pkg::REQ_W-1:0] req_bytes,
  input  logic [bsa_pkg::CLS_W-1:0] req_free_class,
  input  logic [bsa_pkg::OFF_W-1:0] req_free_offset,
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  bsa_pkg::bsa_status_t      res_status,
  input  logic [bsa_pkg::CLS_W-1:0] res_slot_class,
  input  logic [bsa_pkg::OFF_W-1:0] res_slot_offset,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bsa_pkg::LIM_W-1:0] cfg_limit,
  output int                        outstanding,
  output int                        failures
);

  import bsa_pkg::*;

  typedef struct packed {
    bsa_status_t      status;
    logic [CLS_W-1:0] cls;
    logic [OFF_W-1:0] off;
  } grant_t;

  logic [SLOTS_PER_GROUP-1:0] slot_map [CLASS_COUNT][GROUPS];
  logic [GROUPS-1:0]          group_full [CLASS_COUNT];
  logic [LIM_W-1:0]           used_limit;
  grant_t                     grants_due [$];
  grant_t                     want;
  int                         beat_count;

  initial begin
    failures    = 0;
    outstanding = 0;
    beat_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (failures < 200) $display("%0t: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                beat_count, name, got, exp_v));
  endtask

  // applies one request to the mirrored maps and returns the result it owes
  function automatic grant_t predict_beat(input bsa_op_t op, input logic [REQ_W-1:0] nbytes,
                                          input logic [CLS_W-1:0] fcls,
                                          input logic [OFF_W-1:0] foff);
    grant_t      r;
    int unsigned size, cls, slot_bytes, cap, idx, g, b;
    r.status = ST_OK;
    r.cls    = '0;
    r.off    = '0;
    if (op == OP_ALLOC) begin
      size = (nbytes == 0) ? 1 : nbytes;
      cls  = 0;
      if (size >= TOO_LARGE_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else begin
        while (size != 0) begin
          cls++;
          size >>= 1;
        end
        if (cls > CLASS_COUNT) begin
          r.status = ST_TOO_LARGE;
        end else if (&group_full[cls-1]) begin
          r.status = ST_FULL;
        end else begin
          slot_bytes = 1 << cls;
          cap        = (used_limit > PAGE_BYTES) ? PAGE_BYTES : used_limit;
          r.status   = ST_FULL;
          for (idx = 0; idx < GROUPS * SLOTS_PER_GROUP; idx++) begin
            // lowest slot first; stop once a slot would run past the limit
            if (slot_bytes * (idx + 1) > cap) break;
            g = idx / SLOTS_PER_GROUP;
            b = idx % SLOTS_PER_GROUP;
            if (!slot_map[cls-1][g][b]) begin
              slot_map[cls-1][g][b] = 1'b1;
              group_full[cls-1][g]  = &slot_map[cls-1][g];
              r.status = ST_OK;
              r.cls    = CLS_W'(cls);
              r.off    = OFF_W'(slot_bytes * idx);
              break;
            end
          end
        end
      end
    end else begin
      if (fcls < 1 || fcls > CLASS_COUNT) begin
        r.status = ST_BAD_FREE;
      end else begin
        // misaligned offsets fall to the slot they sit in
        idx = foff >> fcls;
        if (idx >= GROUPS * SLOTS_PER_GROUP) begin
          r.status = ST_BAD_FREE;
        end else begin
          g = idx / SLOTS_PER_GROUP;
          b = idx % SLOTS_PER_GROUP;
          slot_map[fcls-1][g][b] = 1'b0;
          group_full[fcls-1][g]  = 1'b0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        group_full[c] = '0;
        for (int g = 0; g < GROUPS; g++) slot_map[c][g] = '0;
      end
      used_limit = LIMIT_RESET;
      grants_due.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (grants_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding", beat_count));
        end else begin
          want = grants_due.pop_front();
          check_field("status", res_status, want.status);
          check_field("slot_class", res_slot_class, want.cls);
          check_field("slot_offset", res_slot_offset, want.off);
        end
        beat_count++;
      end
      if (cfg_valid && cfg_ready) used_limit = cfg_limit;
      if (req_valid && req_ready)
        grants_due.push_back(predict_beat(req_op, req_bytes, req_free_class, req_free_offset));
      outstanding <= grants_due.size();
    end
  end

endmodule

// File: tb/two_level_bitmap_slot_allocator_top_tb.sv
`timescale 1ns / 100ps
// testbench top: request stimulus, limit writes, result back-pressure and verdict
module two_level_bitmap_slot_allocator_top_tb;
  import bsa_pkg::*;

  localparam int CLASS_COUNT     = 10;
  localparam int GROUPS          = 32;
  localparam int SLOTS_PER_GROUP = 32;
  localparam int PAGE_BYTES      = 4096;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 8;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_CHOKE
  } rx_mode_t;

  logic clk;
  logic rst;
  int   outstanding;
  int   failures;
  int   cycle_count = 0;
  int   burst_left  = 0;
  int   rx_left     = 0;
  int   rx_tick     = 0;
  rx_mode_t rx_mode = RX_OPEN;

  bsa_req_if req ();
  bsa_res_if res ();
  bsa_cfg_if cfg ();

  two_level_bitmap_slot_allocator_top #(
    .CLASS_COUNT    (CLASS_COUNT),
    .GROUPS         (GROUPS),
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP),
    .PAGE_BYTES     (PAGE_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  bsa_grant_checker #(
    .CLASS_COUNT    (CLASS_COUNT),
    .GROUPS         (GROUPS),
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP),
    .PAGE_BYTES     (PAGE_BYTES)
  ) u_grant_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_op         (req.op),
    .req_bytes      (req.request_bytes),
    .req_free_class (req.free_class),
    .req_free_offset(req.free_offset),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_status     (res.status),
    .res_slot_class (res.slot_class),
    .res_slot_offset(res.slot_offset),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_limit      (cfg.usable_limit),
    .outstanding    (outstanding),
    .failures       (failures)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_level_bitmap_slot_allocator_top regression: fail");
      $finish;
    end
  end

  // result side stalls on its own schedule of modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:    res.ready <= 1'b1;
      RX_RANDOM:  res.ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: res.ready <= ((rx_tick % 5) < 3);
      default:    res.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic send_beat(input bsa_op_t op, input logic [REQ_W-1:0] nbytes,
                           input logic [CLS_W-1:0] fcls, input logic [OFF_W-1:0] foff);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 6) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req.valid         <= 1'b1;
    req.op            <= op;
    req.request_bytes <= nbytes;
    req.free_class    <= fcls;
    req.free_offset   <= foff;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  // unused fields of each beat carry random values
  task automatic send_alloc(input logic [REQ_W-1:0] nbytes);
    send_beat(OP_ALLOC, nbytes, CLS_W'($urandom), OFF_W'($urandom));
  endtask

  task automatic send_free(input logic [CLS_W-1:0] fcls, input logic [OFF_W-1:0] foff);
    send_beat(OP_FREE, REQ_W'($urandom), fcls, foff);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req.valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg.valid        <= 1'b1;
    cfg.usable_limit <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] pick_alloc_bytes();
    int unsigned pick, c;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return REQ_W'($urandom_range(1024, 4095));
    c = $urandom_range(1, CLASS_COUNT);
    return REQ_W'($urandom_range(1 << (c - 1), (1 << c) - 1));
  endfunction

  task automatic send_random_item();
    int unsigned pick, c, idx;
    logic [OFF_W-1:0] off;
    if ($urandom_range(0, 39) == 0) drain_results();
    if ($urandom_range(0, 19) < 11) begin
      send_alloc(pick_alloc_bytes());
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        c   = $urandom_range(11, 16);
        c   = (c == 16) ? 0 : c;
        off = OFF_W'($urandom);
      end else if (pick == 1) begin
        c   = $urandom_range(1, CLASS_COUNT);
        off = OFF_W'($urandom);
      end else begin
        // mostly low slots, which the lowest-first policy has likely granted
        c   = $urandom_range(1, CLASS_COUNT);
        idx = $urandom_range(0, 10);
        off = OFF_W'(idx << c);
        if ($urandom_range(0, 3) == 0) off = OFF_W'(off + $urandom_range(0, (1 << c) - 1));
      end
      send_free(CLS_W'(c), off);
    end
  endtask

  initial begin
    int unsigned limit_plan [10];
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.op            = OP_ALLOC;
    req.request_bytes = '0;
    req.free_class    = '0;
    req.free_offset   = '0;
    res.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.usable_limit  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset limit
    send_alloc(12'd0);
    send_alloc(12'd1);
    send_alloc(12'd4095);
    send_alloc(12'd1024);
    send_alloc(12'd1023);
    send_alloc(12'd512);
    send_alloc(12'd600);
    send_alloc(12'd513);
    send_free(4'd0, 12'd0);
    send_free(4'd11, 12'd0);
    send_free(4'd15, 12'hFFF);
    send_free(4'd1, 12'd4095);
    send_free(4'd1, 12'd2048);
    send_free(4'd1, 12'd2047);
    send_free(4'd10, 12'd1500);
    send_alloc(12'd700);
    send_free(4'd10, 12'd4095);
    send_alloc(12'd2);
    send_alloc(12'd3);
    send_free(4'd2, 12'd1);
    send_alloc(12'd2);
    send_alloc(12'd255);
    send_alloc(12'd256);

    // fill every group of the smallest class, then churn holes into it
    write_limit(13'd4096);
    repeat (GROUPS * SLOTS_PER_GROUP + 8) send_alloc(REQ_W'($urandom_range(0, 1)));
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_free(4'd1, OFF_W'($urandom_range(0, 2047)));
      else send_alloc(REQ_W'($urandom_range(0, 1)));
    end

    limit_plan = '{8191, 0, 1, 2, 64, 4097, 0, 0, 3948, 4096};
    limit_plan[6] = $urandom_range(1, 4096);
    limit_plan[7] = $urandom_range(1, 4096);
    foreach (limit_plan[i]) begin
      write_limit(LIM_W'(limit_plan[i]));
      repeat (25) send_random_item();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("two_level_bitmap_slot_allocator_top regression: pass");
    end else begin
      $display("two_level_bitmap_slot_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
